// ===== rtl/dvru_pkg.sv =====
// Shared types and constants of the distance-vector route update engine.
`timescale 1ns / 1ps

package dvru_pkg;

    // Number of routes the table holds.
    localparam int T_ENTRIES = 32;
    // Bits of a table index and of a fill count (which must also hold T_ENTRIES itself).
    localparam int IDX_W = (T_ENTRIES > 1) ? $clog2(T_ENTRIES) : 1;
    localparam int CNT_W = $clog2(T_ENTRIES + 1);

    localparam logic [4:0] INFINITY_RESET = 5'd16;

    localparam logic ACT_APPLY  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        OC_NONE         = 3'd0,
        OC_IMPROVED     = 3'd1,
        OC_HOP_CHANGE   = 3'd2,
        OC_ADDED        = 3'd3,
        OC_SELF_REFRESH = 3'd4,
        OC_SELF_ADDED   = 3'd5,
        OC_FULL         = 3'd6
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic        action;
        logic [31:0] destination;
        logic [31:0] neighbor_address;
        logic [31:0] local_interface;
        logic [31:0] advertised_interface;
        logic [4:0]  advertised_cost;
        logic [4:0]  hop_cost;
        logic        last_entry;
    } t_route_in;

    typedef struct packed {
        t_outcome    outcome;
        logic        table_changed;
        logic        found;
        logic [5:0]  route_cost;
        logic [31:0] route_next_hop;
        logic [31:0] route_interface;
        logic        last_result;
    } t_route_out;

    // One stored route.
    typedef struct packed {
        logic [31:0] destination;
        logic [31:0] next_hop;
        logic [31:0] interface_addr;
        logic [5:0]  cost;
    } t_entry;

    // Access requests from the sequencer to the table memory.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_entry;
    } t_tbl_req;

endpackage

// ===== rtl/distance_vector_route_update.sv =====
// Top level of the distance-vector route update engine: sequencer, decisions and result word.
`timescale 1ns / 1ps

//  Channel   Ports                       Handshake
//  ------    --------------------------  --------------------------------------------
//  item in   i_item, start, busy         word taken at a clock edge with start & !busy
//  result    o_result, o_strobe          word valid for one cycle, cannot be held off
//  config    i_cfg_we, i_cfg_wdata       infinity cost written at an edge with i_cfg_we
//
// Every item, apply or lookup, scans the route table from index 0 through one
// memory read per cycle and stops at the first matching destination. An item
// keeps busy high through its scan and its update state; a hit at a low index ends
// sooner than a miss, which reads every stored route. The scan through the single
// read port sets how long busy stays high.
// The result word appears in the same cycle in which busy falls. The receiver cannot stall,
// so there is no back pressure; a new item may be started while that word shows.
// Reset clears the fill count, the modified mark and the sequencer. The table
// memory is not cleared: only entries below the fill count are ever read.

module distance_vector_route_update (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  dvru_pkg::t_route_in   i_item,
    output logic                  o_strobe,
    output dvru_pkg::t_route_out  o_result,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_wdata
);

    localparam logic [dvru_pkg::CNT_W-1:0] FULL_COUNT = dvru_pkg::CNT_W'(dvru_pkg::T_ENTRIES);

    dvru_pkg::t_state     r_state, n_state;
    dvru_pkg::t_route_in  r_item;
    logic [4:0]           r_infinity;
    logic [dvru_pkg::CNT_W-1:0] r_count, n_count;
    logic [dvru_pkg::CNT_W-1:0] r_addr;
    logic [dvru_pkg::IDX_W-1:0] r_rd_idx;
    logic                 r_rd_pend;
    logic                 r_hit;
    logic                 r_modified, n_modified;
    logic                 r_strobe, n_strobe;
    dvru_pkg::t_route_out r_result, n_result;

    dvru_pkg::t_tbl_req   tbl_req;
    dvru_pkg::t_entry     rd_entry;

    logic                 accept;
    logic                 match;
    logic                 issue;
    logic                 scan_miss;
    logic [5:0]           path_cost;
    logic [5:0]           clamp_cost;
    logic [5:0]           infinity_ext;
    logic                 self_loop;
    logic                 full;
    logic                 set_mod;

    dvru_table u_table (
        .i_clk      (i_clk),
        .i_req      (tbl_req),
        .o_rd_entry (rd_entry)
    );

    assign busy     = (r_state != dvru_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The entry read in the previous scan cycle is compared now; the next read
    // goes out only while no match has turned up and entries remain.
    assign match     = (r_state == dvru_pkg::ST_SCAN) && r_rd_pend &&
                       (rd_entry.destination == r_item.destination);
    assign issue     = (r_state == dvru_pkg::ST_SCAN) && !match && (r_addr != r_count);
    assign scan_miss = (r_state == dvru_pkg::ST_SCAN) && !match && (r_addr == r_count);

    assign path_cost    = {1'b0, r_item.advertised_cost} + {1'b0, r_item.hop_cost};
    assign infinity_ext = {1'b0, r_infinity};
    assign clamp_cost   = (path_cost < infinity_ext) ? path_cost : infinity_ext;
    assign self_loop    = (r_item.destination == r_item.advertised_interface);
    assign full         = (r_count == FULL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvru_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dvru_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = dvru_pkg::ST_SCAN;
                end
            end
            dvru_pkg::ST_SCAN: begin
                if (match || scan_miss) begin
                    n_state = dvru_pkg::ST_UPDATE;
                end
            end
            dvru_pkg::ST_UPDATE: begin
                n_state = dvru_pkg::ST_IDLE;
            end
            default: begin
                n_state = dvru_pkg::ST_IDLE;
            end
        endcase
    end

    // Decision and write-back for the item at the end of its scan.
    always_comb begin
        tbl_req.rd_en                   = issue;
        tbl_req.rd_addr                 = r_addr[dvru_pkg::IDX_W-1:0];
        tbl_req.wr_en                   = 1'b0;
        tbl_req.wr_addr                 = r_rd_idx;
        tbl_req.wr_entry.destination    = r_item.destination;
        tbl_req.wr_entry.next_hop       = r_item.neighbor_address;
        tbl_req.wr_entry.interface_addr = r_item.local_interface;
        tbl_req.wr_entry.cost           = path_cost;

        n_count    = r_count;
        n_modified = r_modified;
        n_strobe   = 1'b0;
        set_mod    = 1'b0;

        n_result                 = '0;
        n_result.outcome         = dvru_pkg::OC_NONE;
        n_result.last_result     = r_item.last_entry;

        if (r_state == dvru_pkg::ST_UPDATE) begin
            n_strobe = 1'b1;
            if (r_item.action == dvru_pkg::ACT_LOOKUP) begin
                // A lookup leaves the table and the modified mark alone.
                if (r_hit) begin
                    n_result.found           = 1'b1;
                    n_result.route_cost      = rd_entry.cost;
                    n_result.route_next_hop  = rd_entry.next_hop;
                    n_result.route_interface = rd_entry.interface_addr;
                end
            end else begin
                if (!r_hit) begin
                    // Unknown destination: append it at the fill count.
                    if (full) begin
                        n_result.outcome = dvru_pkg::OC_FULL;
                    end else begin
                        tbl_req.wr_en    = 1'b1;
                        tbl_req.wr_addr  = r_count[dvru_pkg::IDX_W-1:0];
                        n_count          = r_count + dvru_pkg::CNT_W'(1);
                        set_mod          = 1'b1;
                        n_result.outcome = self_loop ? dvru_pkg::OC_SELF_ADDED
                                                     : dvru_pkg::OC_ADDED;
                    end
                end else if (self_loop) begin
                    tbl_req.wr_en          = 1'b1;
                    tbl_req.wr_entry.cost  = {1'b0, r_item.hop_cost};
                    n_result.outcome       = dvru_pkg::OC_SELF_REFRESH;
                end else if (rd_entry.cost > path_cost) begin
                    tbl_req.wr_en    = 1'b1;
                    set_mod          = 1'b1;
                    n_result.outcome = dvru_pkg::OC_IMPROVED;
                end else if ((rd_entry.next_hop == r_item.neighbor_address) &&
                             (rd_entry.cost != path_cost)) begin
                    // The current next hop changed its cost: follow it, clamped
                    // to infinity. Only a route that was reachable counts as a change.
                    tbl_req.wr_en         = 1'b1;
                    tbl_req.wr_entry.cost = clamp_cost;
                    set_mod               = (rd_entry.cost < infinity_ext);
                    n_result.outcome      = dvru_pkg::OC_HOP_CHANGE;
                end

                if (r_item.last_entry) begin
                    n_result.table_changed = r_modified || set_mod;
                    n_modified             = 1'b0;
                end else begin
                    n_modified = r_modified || set_mod;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infinity <= dvru_pkg::INFINITY_RESET;
            r_count    <= '0;
            r_modified <= 1'b0;
            r_strobe   <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_infinity <= i_cfg_wdata;
            end
            r_count    <= n_count;
            r_modified <= n_modified;
            r_strobe   <= n_strobe;
            if (accept) begin
                r_rd_pend <= 1'b0;
                r_hit     <= 1'b0;
            end else if (r_state == dvru_pkg::ST_SCAN) begin
                r_rd_pend <= issue;
                r_hit     <= match;
            end
        end
    end

    // Payload and scan pointers need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_addr <= '0;
        end else if (issue) begin
            r_addr <= r_addr + dvru_pkg::CNT_W'(1);
        end
        if (issue) begin
            r_rd_idx <= r_addr[dvru_pkg::IDX_W-1:0];
        end
        r_result <= n_result;
    end

    // A result word only ever follows the write-back cycle.
    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == dvru_pkg::ST_UPDATE))
        else $error("result strobe without a preceding update cycle");

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("route count beyond table size");

    // A dropped route is reported only when the table is really full.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_result.outcome == dvru_pkg::OC_FULL) |-> full)
        else $error("table full reported with free entries");

    // A lookup hit never carries an apply outcome.
    a_found_no_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_result.found |-> (r_result.outcome == dvru_pkg::OC_NONE) &&
                                       !r_result.table_changed)
        else $error("lookup result carries apply fields");

    // The memory is never read and written in the same cycle.
    a_no_read_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tbl_req.rd_en && tbl_req.wr_en))
        else $error("table read and write overlap");

endmodule

// ===== rtl/dvru_table.sv =====
// Route table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module dvru_table (
    input  logic              i_clk,
    input  dvru_pkg::t_tbl_req i_req,
    output dvru_pkg::t_entry  o_rd_entry
);

    dvru_pkg::t_entry r_mem [dvru_pkg::T_ENTRIES];
    dvru_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== tb/tb_distance_vector_route_update.sv =====
// Self-checking testbench for the distance-vector route update engine.
`timescale 1ns / 1ps

module tb_distance_vector_route_update;

    // A few neighbors that keep coming back, so that updates from the current
    // next hop (the cost-follow case) happen often.
    localparam logic [31:0] NBR_A = 32'hC0A8_0001;
    localparam logic [31:0] NBR_B = 32'hC0A8_0102;
    localparam logic [31:0] NBR_C = 32'hAC10_2003;
    localparam logic [31:0] NBR_D = 32'h0A63_0004;
    localparam logic [31:0] LIF_A = 32'hC0A8_00FE;
    localparam logic [31:0] LIF_B = 32'hC0A8_01FE;
    localparam logic [31:0] LIF_C = 32'hAC10_20FE;

    localparam int WORDS_PER_PHASE = 216;
    localparam int MAX_SHOWN       = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    dvru_pkg::t_route_in  i_item      = '0;
    logic                 o_strobe;
    dvru_pkg::t_route_out o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [4:0]           i_cfg_wdata = '0;

    distance_vector_route_update u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the route table. Entries fill from index 0 and are never
    // removed, so the fill count alone says which entries are valid.
    logic [31:0] rt_dest [dvru_pkg::T_ENTRIES];
    logic [31:0] rt_hop  [dvru_pkg::T_ENTRIES];
    logic [31:0] rt_ifc  [dvru_pkg::T_ENTRIES];
    logic [5:0]  rt_cost [dvru_pkg::T_ENTRIES];
    int          route_count = 0;
    logic        msg_dirty   = 1'b0;
    logic [4:0]  inf_cost    = dvru_pkg::INFINITY_RESET;

    dvru_pkg::t_route_out pending_replies [$];
    dvru_pkg::t_route_out want_reply;
    int                   error_count = 0;

    typedef struct {
        dvru_pkg::t_route_in  w;
        bit                   typed;
        dvru_pkg::t_route_out want;
    } t_plan_row;

    t_plan_row opening_rows [$];

    // Table slot of a route number.
    function automatic logic [dvru_pkg::IDX_W-1:0] slot(input int n);
        return dvru_pkg::IDX_W'(n);
    endfunction

    function automatic dvru_pkg::t_route_in route_word(logic act, logic [31:0] dst,
                                                       logic [31:0] nbr, logic [31:0] lif,
                                                       logic [31:0] aif, logic [4:0] ac,
                                                       logic [4:0] lc, logic last);
        dvru_pkg::t_route_in w;
        w.action               = act;
        w.destination          = dst;
        w.neighbor_address     = nbr;
        w.local_interface      = lif;
        w.advertised_interface = aif;
        w.advertised_cost      = ac;
        w.hop_cost             = lc;
        w.last_entry           = last;
        return w;
    endfunction

    function automatic dvru_pkg::t_route_out route_reply(dvru_pkg::t_outcome oc, logic chg,
                                                         logic fnd, logic [5:0] cost,
                                                         logic [31:0] hop,
                                                         logic [31:0] ifc, logic last);
        dvru_pkg::t_route_out r;
        r.outcome         = oc;
        r.table_changed   = chg;
        r.found           = fnd;
        r.route_cost      = cost;
        r.route_next_hop  = hop;
        r.route_interface = ifc;
        r.last_result     = last;
        return r;
    endfunction

    // Appends a route at the next free slot, or reports the table full.
    function automatic dvru_pkg::t_outcome store_new_route(dvru_pkg::t_route_in w,
                                                           logic [5:0] cost,
                                                           dvru_pkg::t_outcome added_code);
        if (route_count >= dvru_pkg::T_ENTRIES)
            return dvru_pkg::OC_FULL;
        rt_dest[slot(route_count)] = w.destination;
        rt_hop[slot(route_count)]  = w.neighbor_address;
        rt_ifc[slot(route_count)]  = w.local_interface;
        rt_cost[slot(route_count)] = cost;
        route_count++;
        msg_dirty = 1'b1;
        return added_code;
    endfunction

    // Works out the result word of one item and moves the shadow table along.
    function automatic dvru_pkg::t_route_out route_engine_result(dvru_pkg::t_route_in w);
        dvru_pkg::t_route_out r;
        logic [5:0] path;
        logic [5:0] capped;
        logic [5:0] inf6;
        int         hit;
        bit         self_loop;
        r    = route_reply(dvru_pkg::OC_NONE, 1'b0, 1'b0, '0, '0, '0, w.last_entry);
        hit  = -1;
        inf6 = {1'b0, inf_cost};
        for (int i = 0; i < route_count; i++) begin
            if (hit < 0 && rt_dest[slot(i)] == w.destination)
                hit = i;
        end
        if (w.action == dvru_pkg::ACT_LOOKUP) begin
            if (hit >= 0) begin
                r.found           = 1'b1;
                r.route_cost      = rt_cost[slot(hit)];
                r.route_next_hop  = rt_hop[slot(hit)];
                r.route_interface = rt_ifc[slot(hit)];
            end
            return r;
        end
        path      = {1'b0, w.advertised_cost} + {1'b0, w.hop_cost};
        self_loop = (w.destination == w.advertised_interface);
        if (!self_loop) begin
            if (hit < 0) begin
                r.outcome = store_new_route(w, path, dvru_pkg::OC_ADDED);
            end else if (rt_cost[slot(hit)] > path) begin
                rt_hop[slot(hit)]  = w.neighbor_address;
                rt_ifc[slot(hit)]  = w.local_interface;
                rt_cost[slot(hit)] = path;
                msg_dirty          = 1'b1;
                r.outcome          = dvru_pkg::OC_IMPROVED;
            end else if (rt_hop[slot(hit)] == w.neighbor_address &&
                         rt_cost[slot(hit)] != path) begin
                // The current next hop is believed even when it got worse,
                // but never beyond the unreachable metric.
                capped = (path < inf6) ? path : inf6;
                if (rt_cost[slot(hit)] < inf6)
                    msg_dirty = 1'b1;
                rt_ifc[slot(hit)]  = w.local_interface;
                rt_cost[slot(hit)] = capped;
                r.outcome          = dvru_pkg::OC_HOP_CHANGE;
            end
        end else begin
            if (hit >= 0) begin
                // A refresh of a directly attached route does not count as a change.
                rt_hop[slot(hit)]  = w.neighbor_address;
                rt_ifc[slot(hit)]  = w.local_interface;
                rt_cost[slot(hit)] = {1'b0, w.hop_cost};
                r.outcome          = dvru_pkg::OC_SELF_REFRESH;
            end else begin
                r.outcome = store_new_route(w, path, dvru_pkg::OC_SELF_ADDED);
            end
        end
        if (w.last_entry) begin
            r.table_changed = msg_dirty;
            msg_dirty       = 1'b0;
        end
        return r;
    endfunction

    // Mostly known destinations, so that the table's update paths are exercised;
    // the rest are fresh addresses that add routes until the table is full.
    function automatic dvru_pkg::t_route_in random_route_word();
        dvru_pkg::t_route_in w;
        w.action = ($urandom_range(0, 99) < 20) ? dvru_pkg::ACT_LOOKUP : dvru_pkg::ACT_APPLY;
        if (route_count != 0 && $urandom_range(0, 99) < 80)
            w.destination = rt_dest[slot($urandom_range(0, route_count - 1))];
        else
            w.destination = $urandom;
        case ($urandom_range(0, 4))
            0:       w.neighbor_address = NBR_A;
            1:       w.neighbor_address = NBR_B;
            2:       w.neighbor_address = NBR_C;
            3:       w.neighbor_address = NBR_D;
            default: w.neighbor_address = $urandom;
        endcase
        w.local_interface      = $urandom;
        w.advertised_interface = ($urandom_range(0, 99) < 15) ? w.destination : $urandom;
        if ($urandom_range(0, 1) != 0)
            w.advertised_cost = 5'($urandom_range(0, 7));
        else
            w.advertised_cost = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 1) != 0)
            w.hop_cost = 5'($urandom_range(1, 4));
        else
            w.hop_cost = 5'($urandom_range(1, 31));
        w.last_entry           = ($urandom_range(0, 99) < 30);
        return w;
    endfunction

    // Offers one word after an optional gap and returns at the edge that takes it.
    task automatic send_route_word(input dvru_pkg::t_route_in w, input int gap,
                                   input dvru_pkg::t_route_out want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_replies.push_back(want);
    endtask

    // Lets every outstanding result word come back, with a bound.
    task automatic wait_for_replies();
        int waited = 0;
        start <= 1'b0;
        while (pending_replies.size() != 0 && waited < 400) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            error_count += pending_replies.size();
            if (error_count <= MAX_SHOWN)
                $display("%0d result words never arrived", pending_replies.size());
            pending_replies.delete();
        end
        @(posedge i_clk);
    endtask

    task automatic write_infinity(input logic [4:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        inf_cost  = value;
    endtask

    // Prints the expected and the received word of a mismatch.
    task automatic show_mismatch(input dvru_pkg::t_route_out exp_w,
                                 input dvru_pkg::t_route_out got_w);
        $display("mismatch at %0t: expected oc %0d chg %0b fnd %0b cost %0d hop %h ifc %h",
                 $realtime, exp_w.outcome, exp_w.table_changed, exp_w.found,
                 exp_w.route_cost, exp_w.route_next_hop, exp_w.route_interface);
        $display("    expected last %0b", exp_w.last_result);
        $display("                 got oc %0d chg %0b fnd %0b cost %0d hop %h ifc %h",
                 got_w.outcome, got_w.table_changed, got_w.found,
                 got_w.route_cost, got_w.route_next_hop, got_w.route_interface);
        $display("    got last %0b", got_w.last_result);
    endtask

    // Every strobed word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_replies.size() == 0) begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("unexpected result word: outcome %0d last %0b",
                             o_result.outcome, o_result.last_result);
            end else begin
                want_reply = pending_replies.pop_front();
                if (o_result.outcome !== want_reply.outcome
                        || o_result.table_changed !== want_reply.table_changed
                        || o_result.found !== want_reply.found
                        || o_result.route_cost !== want_reply.route_cost
                        || o_result.route_next_hop !== want_reply.route_next_hop
                        || o_result.route_interface !== want_reply.route_interface
                        || o_result.last_result !== want_reply.last_result) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        show_mismatch(want_reply, o_result);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        dvru_pkg::t_route_out miss_reply;
        dvru_pkg::t_route_out want;
        dvru_pkg::t_route_in  w;
        logic [4:0] phase_inf [6];
        int         calm_items;
        int         gap;

        miss_reply = route_reply(dvru_pkg::OC_NONE, 1'b0, 1'b0, '0, '0, '0, 1'b0);

        // Opening rows run with the unreachable metric at its reset value of 16.
        // Lookup on an empty table misses.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_LOOKUP, 32'h0A00_0001, '0, '0, '0,
                                            5'd0, 5'd1, 1'b1),
                                 1'b1, route_reply(dvru_pkg::OC_NONE, 1'b0, 1'b0, '0, '0, '0,
                                                   1'b1)});
        // Lowest address added at cost 1, then the highest as a self-loop at the top cost.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_A, LIF_A,
                                            32'hFFFF_FFFF, 5'd0, 5'd1, 1'b0),
                                 1'b1, route_reply(dvru_pkg::OC_ADDED, 1'b0, 1'b0, '0, '0, '0,
                                                   1'b0)});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'hFFFF_FFFF, NBR_B, LIF_B,
                                            32'hFFFF_FFFF, 5'd31, 5'd31, 1'b1),
                                 1'b1, route_reply(dvru_pkg::OC_SELF_ADDED, 1'b1, 1'b0, '0, '0,
                                                   '0, 1'b1)});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0,
                                            5'd0, 5'd1, 1'b1),
                                 1'b1, route_reply(dvru_pkg::OC_NONE, 1'b0, 1'b1, 6'd62, NBR_B,
                                                   LIF_B, 1'b1)});
        // Current next hop reports a higher cost: followed, then clamped, then clamped
        // again with the old cost already at infinity so nothing counts as modified.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_A, LIF_B,
                                            32'h1111_1111, 5'd9, 5'd1, 1'b1), 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_A, LIF_A,
                                            32'h1111_1111, 5'd31, 5'd31, 1'b0), 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_A, LIF_A,
                                            32'h2222_2222, 5'd20, 5'd5, 1'b1), 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_A, LIF_C,
                                            32'h2222_2222, 5'd20, 5'd5, 1'b1), 1'b0, miss_reply});
        // Worse path from another neighbor is ignored; a cheaper one wins.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_C, LIF_C,
                                            32'h3333_3333, 5'd30, 5'd10, 1'b1), 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_C, LIF_C,
                                            32'h3333_3333, 5'd2, 5'd1, 1'b0), 1'b0, miss_reply});
        // Self-loop refresh of an existing route takes the link cost.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_D, LIF_A,
                                            32'h0000_0000, 5'd31, 5'd7, 1'b1), 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'hFFFF_FFFF, NBR_C, LIF_C,
                                            32'hFFFF_FFFF, 5'd0, 5'd31, 1'b1),
                                 1'b1, route_reply(dvru_pkg::OC_SELF_REFRESH, 1'b0, 1'b0, '0,
                                                   '0, '0, 1'b1)});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_LOOKUP, 32'h0000_0000, '1, '1, '1,
                                            5'd31, 5'd31, 1'b0), 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_LOOKUP, 32'h1234_5678, '0, '0, '0,
                                            5'd0, 5'd1, 1'b0),
                                 1'b1, route_reply(dvru_pkg::OC_NONE, 1'b0, 1'b0, '0, '0, '0,
                                                   1'b0)});
        // Same hop, same cost: nothing to do.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h0000_0000, NBR_D, LIF_B,
                                            32'h4444_4444, 5'd6, 5'd1, 1'b1), 1'b0, miss_reply});
        // Alternating bit patterns on every field.
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'hAAAA_AAAA, 32'h5555_5555,
                                            32'hAAAA_AAAA, 32'h5555_5555, 5'd21, 5'd10, 1'b0),
                                 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_APPLY, 32'h5555_5555, 32'hAAAA_AAAA,
                                            32'h5555_5555, 32'hAAAA_AAAA, 5'd10, 5'd21, 1'b1),
                                 1'b0, miss_reply});
        opening_rows.push_back('{route_word(dvru_pkg::ACT_LOOKUP, 32'hAAAA_AAAA, '0, '0, '0,
                                            5'd0, 5'd1, 1'b1), 1'b0, miss_reply});

        // Register settings for the random phases: both ends of the legal range,
        // the values below it, something in between, and back to the default.
        phase_inf[3'd0] = 5'd31;
        phase_inf[3'd1] = 5'd2;
        phase_inf[3'd2] = 5'd0;
        phase_inf[3'd3] = 5'd1;
        phase_inf[3'd4] = 5'($urandom_range(3, 30));
        phase_inf[3'd5] = dvru_pkg::INFINITY_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[n]) begin
            want = route_engine_result(opening_rows[n].w);
            if (opening_rows[n].typed)
                want = opening_rows[n].want;
            send_route_word(opening_rows[n].w, $urandom_range(0, 3), want);
        end

        calm_items = 0;
        for (int phase = 0; phase < 6; phase++) begin
            wait_for_replies();
            write_infinity(phase_inf[3'(phase)]);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // Now and then a run of back-to-back words, otherwise random gaps.
                if (calm_items == 0 && $urandom_range(0, 99) < 8)
                    calm_items = $urandom_range(10, 40);
                if (calm_items > 0) begin
                    gap = 0;
                    calm_items--;
                end else begin
                    gap = $urandom_range(0, 17);
                end
                w = random_route_word();
                send_route_word(w, gap, route_engine_result(w));
            end
        end

        wait_for_replies();
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
